// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Every user names its clock clk and
// its synchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DTRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtrt assertion failed");

// Next-cycle implication, checked outside reset.
`define DTRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtrt assertion failed");

`endif

// File: src/dtrt_pkg.sv
package dtrt_pkg;

  // Tile geometry. The tile size must be a power of two.
  localparam int TILE_SIZE  = 16;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_TILES_ACROSS = 64;
  localparam int DEF_MAX_TILES_DOWN   = 64;

  // Field widths.
  localparam int PX_W       = 11;
  localparam int ROW_OUT_W  = 6;
  localparam int START_W    = 6;
  localparam int LEN_W      = 7;
  localparam int OFFS_W     = 26;
  localparam int GRID_W     = 7;
  localparam int PITCH_W    = 16;
  localparam int BPP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Tile coordinate width: holds a rounded-up pixel edge in tiles, a grid
  // size and any row address.
  localparam int TC_RAW = PX_W - TILE_SHIFT + 1;
  localparam int TC_W   = (TC_RAW > 9) ? TC_RAW : 9;

  // Register reset values.
  localparam logic [GRID_W-1:0]  RST_TILES_ACROSS   = 7'd64;
  localparam logic [GRID_W-1:0]  RST_TILES_DOWN     = 7'd48;
  localparam logic [PITCH_W-1:0] RST_LINE_PITCH     = 16'd4096;
  localparam logic [BPP_W-1:0]   RST_BITS_PER_PIXEL = 6'd32;

  // Item kinds.
  localparam logic KIND_INVALIDATE = 1'b0;
  localparam logic KIND_FLUSH      = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILES_ACROSS   = 2'd0,
    CFG_TILES_DOWN     = 2'd1,
    CFG_LINE_PITCH     = 2'd2,
    CFG_BITS_PER_PIXEL = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INV,
    ST_FL_START,
    ST_FL_LOAD,
    ST_SCAN,
    ST_EMPTY
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the incoming item
    logic inv_step;    // read the next row of an invalidate
    logic fl_read;     // read the row named by a flush
    logic fl_load;     // load the scan register and write the row back
    logic scan_step;   // advance the run scan by one tile
    logic emit_empty;  // load the empty-row result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic inv_more;    // rows remain to mark
    logic in_grid;     // flush row lies inside the grid
    logic scan_done;   // no run open and no dirty tile left
    logic any_run;     // the current flush reported at least one run
    logic out_free;    // the result register can take a new item
  } ctl_status_t;

endpackage

// File: src/dtrt_in_if.sv
interface dtrt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [dtrt_pkg::PX_W-1:0]      left_px;
  logic [dtrt_pkg::PX_W-1:0]      top_px;
  logic [dtrt_pkg::PX_W-1:0]      right_px;
  logic [dtrt_pkg::PX_W-1:0]      bottom_px;
  logic [dtrt_pkg::ROW_OUT_W-1:0] flush_row;

  modport source (
    output valid, kind, left_px, top_px, right_px, bottom_px, flush_row,
    input  ready
  );

  modport sink (
    input  valid, kind, left_px, top_px, right_px, bottom_px, flush_row,
    output ready
  );
endinterface

// File: src/dtrt_out_if.sv
interface dtrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtrt_pkg::ROW_OUT_W-1:0] run_row;
  logic [dtrt_pkg::START_W-1:0]   run_start;
  logic [dtrt_pkg::LEN_W-1:0]     run_length;
  logic [dtrt_pkg::OFFS_W-1:0]    byte_offset;
  logic                          empty_row;
  logic                          last;

  modport source (
    output valid, run_row, run_start, run_length, byte_offset, empty_row, last,
    input  ready
  );

  modport sink (
    input  valid, run_row, run_start, run_length, byte_offset, empty_row, last,
    output ready
  );
endinterface

// File: src/dtrt_ctrl.sv
`include "assert_macros.svh"

module dtrt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  dtrt_pkg::ctl_status_t status,
  output dtrt_pkg::ctl_cmd_t    cmd
);

  dtrt_pkg::ctl_state_t state_r;
  dtrt_pkg::ctl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dtrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_kind == dtrt_pkg::KIND_FLUSH) ? dtrt_pkg::ST_FL_START
                                                        : dtrt_pkg::ST_INV;
        end
      end
      dtrt_pkg::ST_INV: begin
        if (status.inv_more) begin
          cmd.inv_step = 1'b1;
        end else begin
          state_nxt = dtrt_pkg::ST_IDLE;
        end
      end
      dtrt_pkg::ST_FL_START: begin
        if (status.in_grid) begin
          cmd.fl_read = 1'b1;
          state_nxt   = dtrt_pkg::ST_FL_LOAD;
        end else begin
          state_nxt = dtrt_pkg::ST_EMPTY;
        end
      end
      dtrt_pkg::ST_FL_LOAD: begin
        cmd.fl_load = 1'b1;
        state_nxt   = dtrt_pkg::ST_SCAN;
      end
      dtrt_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = status.any_run ? dtrt_pkg::ST_IDLE : dtrt_pkg::ST_EMPTY;
        end else if (status.out_free) begin
          cmd.scan_step = 1'b1;
        end
      end
      dtrt_pkg::ST_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = dtrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtrt_pkg::ST_IDLE;
      end
    endcase
  end

  // The scan register is loaded in the cycle after the row read.
  `DTRT_ASSERT_SAME(a_load_after_read, state_r == dtrt_pkg::ST_FL_LOAD,
                    $past(state_r) == dtrt_pkg::ST_FL_START)

endmodule

// File: src/dtrt_dpath.sv
`include "assert_macros.svh"

module dtrt_dpath #(
  parameter int MAX_TILES_ACROSS = dtrt_pkg::DEF_MAX_TILES_ACROSS,
  parameter int MAX_TILES_DOWN   = dtrt_pkg::DEF_MAX_TILES_DOWN
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtrt_pkg::ctl_cmd_t                cmd,
  output dtrt_pkg::ctl_status_t             status,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [dtrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtrt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Incoming item
  input  logic                              in_kind,
  input  logic [dtrt_pkg::PX_W-1:0]         in_left_px,
  input  logic [dtrt_pkg::PX_W-1:0]         in_top_px,
  input  logic [dtrt_pkg::PX_W-1:0]         in_right_px,
  input  logic [dtrt_pkg::PX_W-1:0]         in_bottom_px,
  input  logic [dtrt_pkg::ROW_OUT_W-1:0]    in_flush_row,
  // Result register
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dtrt_pkg::ROW_OUT_W-1:0]    out_run_row,
  output logic [dtrt_pkg::START_W-1:0]      out_run_start,
  output logic [dtrt_pkg::LEN_W-1:0]        out_run_length,
  output logic [dtrt_pkg::OFFS_W-1:0]       out_byte_offset,
  output logic                              out_empty_row,
  output logic                              out_last
);

  localparam int MTA   = MAX_TILES_ACROSS;
  localparam int MTD   = MAX_TILES_DOWN;
  localparam int ROW_W = (MTD > 1) ? $clog2(MTD) : 1;
  localparam int CW    = $clog2(MTA + 1);
  localparam int TC_W  = dtrt_pkg::TC_W;
  localparam int GW    = dtrt_pkg::GRID_W;

  // Configuration registers.
  logic [GW-1:0]                    tiles_across_r;
  logic [GW-1:0]                    tiles_down_r;
  logic [dtrt_pkg::PITCH_W-1:0]     line_pitch_r;
  logic [dtrt_pkg::BPP_W-1:0]       bits_per_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_across_r   <= dtrt_pkg::RST_TILES_ACROSS;
      tiles_down_r     <= dtrt_pkg::RST_TILES_DOWN;
      line_pitch_r     <= dtrt_pkg::RST_LINE_PITCH;
      bits_per_pixel_r <= dtrt_pkg::RST_BITS_PER_PIXEL;
    end else if (cfg_we) begin
      case (dtrt_pkg::cfg_idx_t'(cfg_index))
        dtrt_pkg::CFG_TILES_ACROSS:   tiles_across_r   <= cfg_wdata[GW-1:0];
        dtrt_pkg::CFG_TILES_DOWN:     tiles_down_r     <= cfg_wdata[GW-1:0];
        dtrt_pkg::CFG_LINE_PITCH:     line_pitch_r     <= cfg_wdata;
        dtrt_pkg::CFG_BITS_PER_PIXEL: bits_per_pixel_r <= cfg_wdata[dtrt_pkg::BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective grid, clipped to the storage size.
  logic [GW-1:0] w_eff;
  logic [GW-1:0] h_eff;

  always_comb begin
    w_eff = ({2'b00, tiles_across_r} < 9'(MTA)) ? tiles_across_r : GW'(MTA);
    h_eff = ({2'b00, tiles_down_r} < 9'(MTD)) ? tiles_down_r : GW'(MTD);
  end

  // Rectangle in tiles, rounded outward and clipped to the grid.
  logic [TC_W-1:0] cx0;
  logic [TC_W-1:0] cy0;
  logic [TC_W-1:0] cx1;
  logic [TC_W-1:0] cy1;
  logic [TC_W-1:0] cx1_clip;
  logic [TC_W-1:0] cy1_clip;
  logic [MTA-1:0]  rect_mask;
  logic [MTA-1:0]  grid_mask;

  always_comb begin
    cx0 = TC_W'(in_left_px >> dtrt_pkg::TILE_SHIFT);
    cy0 = TC_W'(in_top_px >> dtrt_pkg::TILE_SHIFT);
    cx1 = TC_W'(((dtrt_pkg::PX_W + 1)'(in_right_px) +
                 (dtrt_pkg::PX_W + 1)'(dtrt_pkg::TILE_SIZE - 1)) >> dtrt_pkg::TILE_SHIFT);
    cy1 = TC_W'(((dtrt_pkg::PX_W + 1)'(in_bottom_px) +
                 (dtrt_pkg::PX_W + 1)'(dtrt_pkg::TILE_SIZE - 1)) >> dtrt_pkg::TILE_SHIFT);
    cx1_clip = (cx1 > TC_W'(w_eff)) ? TC_W'(w_eff) : cx1;
    cy1_clip = (cy1 > TC_W'(h_eff)) ? TC_W'(h_eff) : cy1;
    for (int c = 0; c < MTA; c++) begin
      rect_mask[c] = (TC_W'(c) >= cx0) && (TC_W'(c) < cx1_clip);
      grid_mask[c] = (TC_W'(c) < TC_W'(w_eff));
    end
  end

  // Item registers: row counter (or flush row), end row and column mask.
  logic [TC_W-1:0] row_r;
  logic [TC_W-1:0] row_end_r;
  logic [MTA-1:0]  mask_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_kind == dtrt_pkg::KIND_FLUSH) begin
        row_r <= TC_W'(in_flush_row);
      end else begin
        row_r <= cy0;
      end
      row_end_r <= cy1_clip;
      mask_r    <= rect_mask;
    end else if (cmd.inv_step) begin
      row_r <= row_r + TC_W'(1);
    end
  end

  // Dirty map: one word per tile row, with a valid bit per row that
  // reset clears so an unwritten row reads as clean.
  logic [MTA-1:0]   dirty_rows_r [MTD];
  logic [MTD-1:0]   row_valid_r;
  logic [MTA-1:0]   rd_q_r;
  logic             rd_vld_r;
  logic             inv_pend_r;
  logic [ROW_W-1:0] inv_addr_r;
  logic [MTA-1:0]   rd_data;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [MTA-1:0]   wr_data;

  always_comb begin
    rd_en   = cmd.inv_step | cmd.fl_read;
    rd_addr = row_r[ROW_W-1:0];
    rd_data = rd_vld_r ? rd_q_r : '0;
    wr_en   = inv_pend_r | cmd.fl_load;
    wr_addr = inv_pend_r ? inv_addr_r : row_r[ROW_W-1:0];
    wr_data = inv_pend_r ? (rd_data | mask_r) : (rd_data & ~grid_mask);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dirty_rows_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= dirty_rows_r[rd_addr];
      rd_vld_r <= row_valid_r[rd_addr];
    end
  end

  // Row valid bits and the pending read-modify-write of an invalidate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      inv_pend_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      inv_pend_r <= cmd.inv_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inv_step) begin
      inv_addr_r <= rd_addr;
    end
  end

  // Row part of the byte offset, computed while the row is read.
  logic [dtrt_pkg::OFFS_W-1:0] row_term_r;

  always_ff @(posedge clk) begin
    if (cmd.fl_read) begin
      row_term_r <= dtrt_pkg::OFFS_W'((32'(row_r) * 32'(line_pitch_r))
                                      << dtrt_pkg::TILE_SHIFT);
    end
  end

  // Run scan: the row word shifts down one tile a step.
  logic [MTA-1:0] bits_r;
  logic [CW-1:0]  col_r;
  logic [CW-1:0]  start_r;
  logic           run_on_r;
  logic           any_r;
  logic           emit_run;

  assign emit_run = cmd.scan_step && run_on_r && !bits_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= '0;
      run_on_r <= 1'b0;
      any_r    <= 1'b0;
      col_r    <= '0;
    end else if (cmd.fl_load) begin
      bits_r   <= rd_data & grid_mask;
      run_on_r <= 1'b0;
      any_r    <= 1'b0;
      col_r    <= '0;
    end else if (cmd.scan_step) begin
      bits_r <= bits_r >> 1;
      col_r  <= col_r + CW'(1);
      if (!run_on_r && bits_r[0]) begin
        run_on_r <= 1'b1;
      end else if (emit_run) begin
        run_on_r <= 1'b0;
        any_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && !run_on_r && bits_r[0]) begin
      start_r <= col_r;
    end
  end

  // Column part of the byte offset for the run being reported.
  logic [31:0]                 col_prod;
  logic [dtrt_pkg::OFFS_W-1:0] run_offs;

  always_comb begin
    col_prod = (32'(start_r) * 32'(bits_per_pixel_r)) << dtrt_pkg::TILE_SHIFT;
    run_offs = row_term_r + dtrt_pkg::OFFS_W'(col_prod >> 3);
  end

  // Result register.
  logic                             out_valid_r;
  logic [dtrt_pkg::ROW_OUT_W-1:0]   out_run_row_r;
  logic [dtrt_pkg::START_W-1:0]     out_run_start_r;
  logic [dtrt_pkg::LEN_W-1:0]       out_run_length_r;
  logic [dtrt_pkg::OFFS_W-1:0]      out_byte_offset_r;
  logic                             out_empty_row_r;
  logic                             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_run || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_run) begin
      out_run_row_r     <= row_r[dtrt_pkg::ROW_OUT_W-1:0];
      out_run_start_r   <= dtrt_pkg::START_W'(start_r);
      out_run_length_r  <= dtrt_pkg::LEN_W'(col_r - start_r);
      out_byte_offset_r <= run_offs;
      out_empty_row_r   <= 1'b0;
      out_last_r        <= (bits_r == '0);
    end else if (cmd.emit_empty) begin
      out_run_row_r     <= row_r[dtrt_pkg::ROW_OUT_W-1:0];
      out_run_start_r   <= '0;
      out_run_length_r  <= '0;
      out_byte_offset_r <= '0;
      out_empty_row_r   <= 1'b1;
      out_last_r        <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_run_row     = out_run_row_r;
  assign out_run_start   = out_run_start_r;
  assign out_run_length  = out_run_length_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_empty_row   = out_empty_row_r;
  assign out_last        = out_last_r;

  // Status back to the controller.
  always_comb begin
    status.inv_more  = (row_r < row_end_r);
    status.in_grid   = (row_r < TC_W'(h_eff));
    status.scan_done = !run_on_r && (bits_r == '0);
    status.any_run   = any_r;
    status.out_free  = !out_valid_r || out_ready;
  end

  // The invalidate write-back and the flush write-back never share a cycle.
  `DTRT_ASSERT_SAME(a_single_writer, inv_pend_r, !cmd.fl_load)
  // A run reported as last leaves the scan finished.
  `DTRT_ASSERT_NEXT(a_last_ends_scan, emit_run && (bits_r == '0), status.scan_done)
  // A run is only reported into a free result register.
  `DTRT_ASSERT_SAME(a_emit_when_free, emit_run || cmd.emit_empty,
                    !out_valid_r || out_ready)

endmodule

// File: src/dirty_tile_run_tracker.sv
// Invalidate: after the accept, each covered tile row (up to 64) is read and then written back
// with the new bits; the next item is taken once the last row write is done.
// Flush: accept, row read and row write-back, then one scan step per column up to the grid
// width plus one (held while the result register is full) and a closing step; an empty row
// adds a step for its result.
// Synchronous active-low reset loads the register defaults and clears per-row valid bits.
module dirty_tile_run_tracker #(
  parameter int MAX_TILES_ACROSS = dtrt_pkg::DEF_MAX_TILES_ACROSS,
  parameter int MAX_TILES_DOWN   = dtrt_pkg::DEF_MAX_TILES_DOWN
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dtrt_in_if.sink                         in_ch,
  dtrt_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dtrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dtrt_pkg::ctl_cmd_t    cmd;
  dtrt_pkg::ctl_status_t status;

  // Sequencer for invalidate and flush items.
  dtrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Dirty map, run scan and result register.
  dtrt_dpath #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_left_px      (in_ch.left_px),
    .in_top_px       (in_ch.top_px),
    .in_right_px     (in_ch.right_px),
    .in_bottom_px    (in_ch.bottom_px),
    .in_flush_row    (in_ch.flush_row),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_run_row     (out_ch.run_row),
    .out_run_start   (out_ch.run_start),
    .out_run_length  (out_ch.run_length),
    .out_byte_offset (out_ch.byte_offset),
    .out_empty_row   (out_ch.empty_row),
    .out_last        (out_ch.last)
  );

endmodule

// File: tb/dirty_tile_run_tracker_tb.sv
`timescale 1ns / 1ps

module dirty_tile_run_tracker_tb;

  localparam int GRID_MAX_ACROSS = dtrt_pkg::DEF_MAX_TILES_ACROSS;
  localparam int GRID_MAX_DOWN   = dtrt_pkg::DEF_MAX_TILES_DOWN;
  localparam int PX_LIMIT        = (1 << dtrt_pkg::PX_W) - 1;
  // An invalidate may still be walking rows after the last result is out.
  localparam int MAP_SETTLE      = 2 * GRID_MAX_DOWN + 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_PRINTED     = 30;

  typedef struct packed {
    logic                           kind;
    logic [dtrt_pkg::PX_W-1:0]      left_px;
    logic [dtrt_pkg::PX_W-1:0]      top_px;
    logic [dtrt_pkg::PX_W-1:0]      right_px;
    logic [dtrt_pkg::PX_W-1:0]      bottom_px;
    logic [dtrt_pkg::ROW_OUT_W-1:0] flush_row;
  } tile_req_t;

  typedef struct packed {
    logic [dtrt_pkg::ROW_OUT_W-1:0] run_row;
    logic [dtrt_pkg::START_W-1:0]   run_start;
    logic [dtrt_pkg::LEN_W-1:0]     run_length;
    logic [dtrt_pkg::OFFS_W-1:0]    byte_offset;
    logic                           empty_row;
    logic                           last;
  } run_rec_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [dtrt_pkg::CFG_IDX_W-1:0]  cfg_index = dtrt_pkg::CFG_TILES_ACROSS;
  logic [dtrt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  dtrt_in_if  in_ch ();
  dtrt_out_if out_ch ();

  dirty_tile_run_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow copy of the dirty map and the registers.
  logic [GRID_MAX_ACROSS-1:0]      dirty_map [GRID_MAX_DOWN] = '{default: '0};
  logic [dtrt_pkg::GRID_W-1:0]     across_reg = dtrt_pkg::RST_TILES_ACROSS;
  logic [dtrt_pkg::GRID_W-1:0]     down_reg   = dtrt_pkg::RST_TILES_DOWN;
  logic [dtrt_pkg::PITCH_W-1:0]    pitch_reg  = dtrt_pkg::RST_LINE_PITCH;
  logic [dtrt_pkg::BPP_W-1:0]      bpp_reg    = dtrt_pkg::RST_BITS_PER_PIXEL;

  tile_req_t   req_queue [$];
  run_rec_t    expected_runs [$];
  tile_req_t   cur_req = '0;

  int unsigned issued = 0;
  int unsigned n_items = 0;
  int unsigned n_flushes = 0;
  int unsigned n_results = 0;
  int unsigned max_runs = 0;
  int unsigned err_count = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_draw = 0;
  int unsigned hold_left = 0;
  int unsigned hold_trig = 0;
  int unsigned hold_ack = 0;
  int unsigned stall_cycles = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  function automatic int unsigned grid_across();
    return (across_reg < GRID_MAX_ACROSS) ? across_reg : GRID_MAX_ACROSS;
  endfunction

  function automatic int unsigned grid_down();
    return (down_reg < GRID_MAX_DOWN) ? down_reg : GRID_MAX_DOWN;
  endfunction

  // Round the rectangle outward to tiles, clip to the grid and set the bits.
  function automatic void mark_tiles(input tile_req_t req);
    int unsigned col_lo, row_lo, col_hi, row_hi, c, r;
    logic [GRID_MAX_ACROSS-1:0] cols;
    col_lo = req.left_px / dtrt_pkg::TILE_SIZE;
    row_lo = req.top_px / dtrt_pkg::TILE_SIZE;
    col_hi = (req.right_px + dtrt_pkg::TILE_SIZE - 1) / dtrt_pkg::TILE_SIZE;
    row_hi = (req.bottom_px + dtrt_pkg::TILE_SIZE - 1) / dtrt_pkg::TILE_SIZE;
    if (col_hi > grid_across()) col_hi = grid_across();
    if (row_hi > grid_down()) row_hi = grid_down();
    cols = '0;
    for (c = col_lo; c < col_hi; c++) cols[c] = 1'b1;
    for (r = row_lo; r < row_hi; r++) dirty_map[r] |= cols;
  endfunction

  // Scan one tile row left to right, queue each run found and clear it.
  function automatic void collect_runs(input logic [dtrt_pkg::ROW_OUT_W-1:0] row);
    int unsigned width, col, start;
    logic [GRID_MAX_ACROSS-1:0] bits;
    longint unsigned offs;
    run_rec_t rec;
    run_rec_t found [$];
    width = grid_across();
    col = 0;
    if (row < grid_down()) begin
      bits = dirty_map[row];
      while (col < width) begin
        if (!bits[col]) begin
          col++;
        end else begin
          start = col;
          while (col < width && bits[col]) begin
            dirty_map[row][col] = 1'b0;
            col++;
          end
          offs = longint'(row) * dtrt_pkg::TILE_SIZE * pitch_reg
               + (longint'(start) * dtrt_pkg::TILE_SIZE * bpp_reg) / 8;
          rec.run_row     = row;
          rec.run_start   = start[dtrt_pkg::START_W-1:0];
          rec.run_length  = dtrt_pkg::LEN_W'(col - start);
          rec.byte_offset = offs[dtrt_pkg::OFFS_W-1:0];
          rec.empty_row   = 1'b0;
          rec.last        = 1'b0;
          found.push_back(rec);
        end
      end
    end
    if (found.size() == 0) begin
      rec = '0;
      rec.run_row   = row;
      rec.empty_row = 1'b1;
      rec.last      = 1'b1;
      found.push_back(rec);
    end else begin
      found[found.size()-1].last = 1'b1;
      if (found.size() > max_runs) max_runs = found.size();
    end
    foreach (found[i]) expected_runs.push_back(found[i]);
  endfunction

  function automatic void apply_item(input tile_req_t req);
    if (req.kind == dtrt_pkg::KIND_INVALIDATE) mark_tiles(req);
    else collect_runs(req.flush_row);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("ERROR: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                n_results, name, got, want));
  endtask

  task automatic check_run(input run_rec_t got);
    run_rec_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected result: row %0d start %0d length %0d",
                                got.run_row, got.run_start, got.run_length));
    end else begin
      want = expected_runs.pop_front();
      compare_field("run_row", 32'(got.run_row), 32'(want.run_row));
      compare_field("run_start", 32'(got.run_start), 32'(want.run_start));
      compare_field("run_length", 32'(got.run_length), 32'(want.run_length));
      compare_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
      compare_field("empty_row", 32'(got.empty_row), 32'(want.empty_row));
      compare_field("last", 32'(got.last), 32'(want.last));
    end
    n_results++;
  endtask

  // Driver: present queued items, with a drawn gap after each acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(cur_req);
        n_items++;
        if (cur_req.kind == dtrt_pkg::KIND_FLUSH) n_flushes++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_wait != 0) begin
          tx_wait     <= tx_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req           <= req_queue[0];
          in_ch.kind        <= req_queue[0].kind;
          in_ch.left_px     <= req_queue[0].left_px;
          in_ch.top_px      <= req_queue[0].top_px;
          in_ch.right_px    <= req_queue[0].right_px;
          in_ch.bottom_px   <= req_queue[0].bottom_px;
          in_ch.flush_row   <= req_queue[0].flush_row;
          in_ch.valid       <= 1'b1;
          tx_wait           <= tx_calm ? 0 : $urandom_range(0, 7);
          void'(req_queue.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result and pace ready, with an occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_run({out_ch.run_row, out_ch.run_start, out_ch.run_length,
                   out_ch.byte_offset, out_ch.empty_row, out_ch.last});
      if (hold_trig != hold_ack) begin
        hold_ack     <= hold_trig;
        hold_left    <= HOLD_CYCLES;
        rx_wait      <= 0;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else if (out_ch.valid && out_ch.ready) begin
        rx_draw       = rx_calm ? 0 : $urandom_range(0, 7);
        rx_wait      <= rx_draw;
        out_ch.ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        out_ch.ready <= (rx_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("dirty_tile_run_tracker: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int clip_px(input int v);
    return (v < 0) ? 0 : (v > PX_LIMIT) ? PX_LIMIT : v;
  endfunction

  function automatic logic [dtrt_pkg::PX_W-1:0] rand_px();
    return dtrt_pkg::PX_W'($urandom_range(0, PX_LIMIT));
  endfunction

  task automatic push_rect(input int l, input int t, input int r, input int b);
    tile_req_t req;
    req.kind      = dtrt_pkg::KIND_INVALIDATE;
    req.left_px   = dtrt_pkg::PX_W'(clip_px(l));
    req.top_px    = dtrt_pkg::PX_W'(clip_px(t));
    req.right_px  = dtrt_pkg::PX_W'(clip_px(r));
    req.bottom_px = dtrt_pkg::PX_W'(clip_px(b));
    req.flush_row = dtrt_pkg::ROW_OUT_W'($urandom_range(0, 63));
    req_queue.push_back(req);
    issued++;
  endtask

  task automatic push_flush(input int unsigned row);
    tile_req_t req;
    req.kind      = dtrt_pkg::KIND_FLUSH;
    req.left_px   = rand_px();
    req.top_px    = rand_px();
    req.right_px  = rand_px();
    req.bottom_px = rand_px();
    req.flush_row = row[dtrt_pkg::ROW_OUT_W-1:0];
    req_queue.push_back(req);
    issued++;
  endtask

  function automatic int unsigned pick_row();
    if (grid_down() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, grid_down() - 1);
  endfunction

  // Small rectangle somewhere inside the pixel area of the grid.
  task automatic push_rect_in_grid();
    int gx, gy, l, t;
    gx = (grid_across() == 0) ? 64 : grid_across() * dtrt_pkg::TILE_SIZE;
    gy = (grid_down() == 0) ? 64 : grid_down() * dtrt_pkg::TILE_SIZE;
    l = $urandom_range(0, gx);
    t = $urandom_range(0, gy);
    push_rect(l, t, l + $urandom_range(0, 4 * dtrt_pkg::TILE_SIZE),
              t + $urandom_range(0, 3 * dtrt_pkg::TILE_SIZE));
  endtask

  // Rectangle that straddles the right and bottom edges of the grid.
  task automatic push_rect_on_edge();
    int l, t;
    l = grid_across() * dtrt_pkg::TILE_SIZE - $urandom_range(0, 40);
    t = grid_down() * dtrt_pkg::TILE_SIZE - $urandom_range(0, 40);
    push_rect(l, t, l + $urandom_range(0, 200), t + $urandom_range(0, 200));
  endtask

  // Every other tile of one row: the most runs a single flush can give.
  task automatic push_comb();
    int unsigned row, c;
    row = pick_row();
    push_flush(row);
    for (c = 0; c < grid_across(); c += 2)
      push_rect(c * dtrt_pkg::TILE_SIZE, row * dtrt_pkg::TILE_SIZE,
                (c + 1) * dtrt_pkg::TILE_SIZE, row * dtrt_pkg::TILE_SIZE + 1);
    push_flush(row);
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned stop_at, pick;
    stop_at = issued + budget;
    while (issued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat ($urandom_range(1, 4)) push_rect_in_grid();
        repeat ($urandom_range(1, 3)) push_flush(pick_row());
      end else if (pick < 57) begin
        push_comb();
      end else if (pick < 72) begin
        push_flush($urandom_range(0, 63));
      end else if (pick < 87) begin
        push_rect(rand_px(), rand_px(), rand_px(), rand_px());
      end else begin
        push_rect_on_edge();
      end
    end
  endtask

  // Sender pause: wait until every item is in and every result is out.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_ch.valid || expected_runs.size() != 0)
      @(posedge clk);
    repeat (MAP_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input dtrt_pkg::cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[dtrt_pkg::CFG_DATA_W-1:0];
    case (idx)
      dtrt_pkg::CFG_TILES_ACROSS:   across_reg = value[dtrt_pkg::GRID_W-1:0];
      dtrt_pkg::CFG_TILES_DOWN:     down_reg   = value[dtrt_pkg::GRID_W-1:0];
      dtrt_pkg::CFG_LINE_PITCH:     pitch_reg  = value[dtrt_pkg::PITCH_W-1:0];
      dtrt_pkg::CFG_BITS_PER_PIXEL: bpp_reg    = value[dtrt_pkg::BPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned across, input int unsigned down,
                          input int unsigned pitch, input int unsigned bpp);
    write_reg(dtrt_pkg::CFG_TILES_ACROSS, across);
    write_reg(dtrt_pkg::CFG_TILES_DOWN, down);
    write_reg(dtrt_pkg::CFG_LINE_PITCH, pitch);
    write_reg(dtrt_pkg::CFG_BITS_PER_PIXEL, bpp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset grid of 64 by 48 tiles.
    push_rect(0, 0, 1, 1);
    push_rect(1008, 752, 1024, 768);
    push_flush(0);
    push_flush(47);
    push_flush(5);
    push_flush(63);
    push_rect(0, 0, 1024, 16);
    push_flush(0);
    push_rect(PX_LIMIT, PX_LIMIT, PX_LIMIT, PX_LIMIT);
    push_rect(500, 500, 100, 100);
    push_rect(32, 32, 32, 48);
    push_flush(2);
    push_rect(17, 30, 47, 33);
    push_rect(80, 16, 81, 17);
    push_flush(1);
    push_flush(2);
    push_rect(0, 0, 1024, 1024);
    push_flush(47);
    push_flush(20);
    push_rect(PX_LIMIT, 0, 0, PX_LIMIT);
    wait_drained();

    // A stretch with no idling on either side.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    random_phase(20);
    wait_drained();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Largest settings, with a long receiver hold while items keep coming.
    set_grid(64, 64, 65535, 63);
    random_phase(8);
    @(posedge clk);
    hold_trig <= hold_trig + 1;
    push_comb();
    repeat (6) push_rect_in_grid();
    repeat (6) push_flush(pick_row());
    random_phase(12);
    wait_drained();

    set_grid(1, 1, 0, 8);
    random_phase(10);
    wait_drained();

    // Empty grid, then register values above the maximum grid.
    set_grid(0, 0, 1234, 0);
    random_phase(8);
    wait_drained();
    set_grid(127, 127, $urandom_range(0, 65535), $urandom_range(0, 63));
    random_phase(12);
    wait_drained();

    set_grid(13, 9, $urandom_range(0, 65535), 2 * $urandom_range(0, 31) + 1);
    random_phase(20);
    wait_drained();

    // Shrink the grid, then grow it back and flush the whole frame.
    set_grid(5, 3, $urandom_range(0, 65535), $urandom_range(0, 63));
    random_phase(8);
    wait_drained();
    set_grid(64, 64, $urandom_range(0, 65535), $urandom_range(0, 63));
    for (int unsigned r = 0; r < GRID_MAX_DOWN; r++) push_flush(r);
    wait_drained();

    set_grid($urandom_range(0, 127), $urandom_range(0, 127),
             $urandom_range(0, 65535), $urandom_range(0, 63));
    random_phase(12);
    wait_drained();

    $display("covered %0d items (%0d flushes) and %0d results, up to %0d runs in one row",
             n_items, n_flushes, n_results, max_runs);
    $display("grids from empty to oversized, shrink and regrow, %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("dirty_tile_run_tracker: match");
    end else begin
      $display("dirty_tile_run_tracker: mismatch");
    end
    $finish;
  end

endmodule
